[hdl/three_voice_sound_generator_defines.svh]
// Assertion macros shared by the sound generator RTL
`ifndef THREE_VOICE_SOUND_GENERATOR_DEFINES_SVH
`define THREE_VOICE_SOUND_GENERATOR_DEFINES_SVH

// implication checked on every clock unless in reset
`define TVSG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define TVSG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/tvsg_pkg.sv]
package tvsg_pkg;

  localparam int unsigned TONE_CHANNELS = 3;
  localparam int unsigned CH_W = (TONE_CHANNELS > 1) ? $clog2(TONE_CHANNELS) : 1;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ADDR  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TONE,
    ST_NOISE,
    ST_GATE,
    ST_ENV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [3:0]  level_a;
    logic        env_a;
    logic [3:0]  level_b;
    logic        env_b;
    logic [3:0]  level_c;
    logic        env_c;
    logic [17:0] sum_level;
  } out_item_t;

  function automatic logic [7:0] read_mask(input logic [3:0] idx);
    logic [7:0] m;
    case (idx)
      4'd1, 4'd3, 4'd5, 4'd13: m = 8'h0f;
      4'd6, 4'd8, 4'd9, 4'd10: m = 8'h1f;
      default:                 m = 8'hff;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] level_value(input logic [3:0] lvl);
    logic [15:0] v;
    case (lvl)
      4'd0:  v = 16'd0;
      4'd1:  v = 16'd771;
      4'd2:  v = 16'd1028;
      4'd3:  v = 16'd1542;
      4'd4:  v = 16'd2570;
      4'd5:  v = 16'd3855;
      4'd6:  v = 16'd5397;
      4'd7:  v = 16'd8738;
      4'd8:  v = 16'd10280;
      4'd9:  v = 16'd16705;
      4'd10: v = 16'd23387;
      4'd11: v = 16'd29298;
      4'd12: v = 16'd37008;
      4'd13: v = 16'd46517;
      4'd14: v = 16'd55255;
      default: v = 16'd65535;
    endcase
    return v;
  endfunction

endpackage

[hdl/tvsg_tone_div.sv]
// Shared tone divider: quotient/remainder of a 12-bit count by a 12-bit period,
// one restoring step per cycle.
module tvsg_tone_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [11:0] dividend,
  input  logic [11:0] divisor,
  output logic        done,
  output logic [11:0] quot,
  output logic [11:0] rem
);

  logic [3:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [11:0] q_r, q_nxt;
  logic [12:0] rem_r, rem_nxt;
  logic [11:0] d_r, d_nxt;
  logic [12:0] trial;

  // load on start, one shift-subtract step while busy, then done
  always_comb begin
    trial    = {rem_r[11:0], q_r[11]};
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    done     = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd0;
      q_nxt    = dividend;
      rem_nxt  = 13'd0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[10:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[10:0], 1'b0};
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd11) busy_nxt = 1'b0;
    end else if (cnt_r == 4'd12) begin
      done    = 1'b1;
      cnt_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 4'd0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign quot = q_r;
  assign rem  = rem_r[11:0];

endmodule

[hdl/three_voice_sound_generator.sv]
// Register commands pass through the ST_OUT state and then the out_valid register;
// a clock tick runs ST_TONE once per tone channel on the shared divider, then
// ST_NOISE, ST_GATE, ST_ENV and ST_OUT. Handshake: one request at a time; the
// next request is taken the cycle after the result is accepted.
// Reset: synchronous active-low rst_n clears registers and tone/noise/envelope
// state; the LFSR resets to one and the chip starts selected.
`include "three_voice_sound_generator_defines.svh"
module three_voice_sound_generator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tvsg_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tvsg_pkg::out_item_t  out_data
);

  localparam int unsigned NCH = tvsg_pkg::TONE_CHANNELS;
  localparam int unsigned CW  = tvsg_pkg::CH_W;

  tvsg_pkg::state_t state_r, state_nxt;

  logic [7:0]  reg_file_r [16];
  logic [4:0]  sel_r;
  logic        selected_r;
  logic [11:0] tone_cnt_r [NCH];
  logic [4:0]  duty_r [NCH];
  logic        tone_out_r [NCH];
  logic        gate_r [NCH];
  logic [4:0]  noise_cnt_r;
  logic        prescale_r;
  logic [16:0] lfsr_r;
  logic [16:0] env_cnt_r;
  logic [3:0]  env_step_r;
  logic [3:0]  env_attack_r;
  logic        env_hold_r, env_alt_r, env_holding_r;
  logic [CW-1:0] ch_r;
  logic        div_busy_r;
  logic [7:0]  rd_r;
  tvsg_pkg::out_item_t out_r;

  // request capture
  logic acc;
  assign in_ready = (state_r == tvsg_pkg::ST_IDLE) && !out_valid;
  assign acc      = in_valid && in_ready;

  // shared divider for tone channel ch_r
  logic [3:0]  ri_f, ri_c;
  logic [11:0] period, cnt_inc, quot, rem;
  logic        div_start, div_done;
  assign ri_f      = 4'((32'(ch_r) * 2) & 32'hf);
  assign ri_c      = 4'((32'(ch_r) * 2 + 1) & 32'hf);
  assign period    = ({reg_file_r[ri_c][3:0], reg_file_r[ri_f]} == 12'd0) ? 12'd1 :
                     {reg_file_r[ri_c][3:0], reg_file_r[ri_f]};
  assign cnt_inc   = tone_cnt_r[ch_r] + 12'd1;
  assign div_start = (state_r == tvsg_pkg::ST_TONE) && !div_busy_r;

  tvsg_tone_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cnt_inc),
    .divisor  (period),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tvsg_pkg::ST_IDLE:  if (acc) state_nxt = (in_data.cmd == tvsg_pkg::CMD_TICK) ?
                                      tvsg_pkg::ST_TONE : tvsg_pkg::ST_OUT;
      tvsg_pkg::ST_TONE:  if (div_done && 32'(ch_r) == NCH - 1) state_nxt = tvsg_pkg::ST_NOISE;
      tvsg_pkg::ST_NOISE: state_nxt = tvsg_pkg::ST_GATE;
      tvsg_pkg::ST_GATE:  state_nxt = tvsg_pkg::ST_ENV;
      tvsg_pkg::ST_ENV:   state_nxt = tvsg_pkg::ST_OUT;
      tvsg_pkg::ST_OUT:   state_nxt = tvsg_pkg::ST_IDLE;
      default:            state_nxt = tvsg_pkg::ST_IDLE;
    endcase
  end

  // result assembly from current state
  logic [3:0]  lvl [3];
  logic        env [3];
  logic [17:0] sum;
  always_comb begin
    sum = 18'd0;
    for (int c = 0; c < 3; c++) begin
      lvl[c] = 4'd0;
      env[c] = 1'b0;
      if (c < NCH) begin
        env[c] = reg_file_r[8 + c][4];
        if (gate_r[c]) lvl[c] = env[c] ? (env_step_r ^ env_attack_r) :
                                          reg_file_r[8 + c][3:0];
      end
      sum = sum + 18'(tvsg_pkg::level_value(lvl[c]));
    end
  end

  logic nz_fire, env_fire;
  logic [4:0]  nz_inc;
  logic [16:0] env_inc;
  logic [16:0] env_period;
  assign nz_inc     = noise_cnt_r + 5'd1;
  assign nz_fire    = (nz_inc >= reg_file_r[6][4:0]) || (nz_inc == 5'd0);
  assign env_inc    = env_cnt_r + 17'd1;
  assign env_period = {reg_file_r[12], reg_file_r[11], 1'b0};
  assign env_fire   = env_inc >= env_period;

  function automatic logic en_bit(input logic [7:0] r7, input int b);
    return (b > 7) ? 1'b0 : r7[b];
  endfunction

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tvsg_pkg::ST_IDLE;
      for (int i = 0; i < 16; i++) reg_file_r[i] <= 8'd0;
      sel_r         <= 5'd0;
      selected_r    <= 1'b1;
      for (int c = 0; c < NCH; c++) begin
        tone_cnt_r[c] <= 12'd0;
        duty_r[c]     <= 5'd0;
        tone_out_r[c] <= 1'b0;
        gate_r[c]     <= 1'b0;
      end
      noise_cnt_r   <= 5'd0;
      prescale_r    <= 1'b0;
      lfsr_r        <= 17'd1;
      env_cnt_r     <= 17'd0;
      env_step_r    <= 4'd0;
      env_attack_r  <= 4'd0;
      env_hold_r    <= 1'b0;
      env_alt_r     <= 1'b0;
      env_holding_r <= 1'b0;
      ch_r          <= '0;
      div_busy_r    <= 1'b0;
      rd_r          <= 8'd0;
      out_valid     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state_r)
        tvsg_pkg::ST_IDLE: if (acc) begin
          ch_r <= '0;
          case (in_data.cmd)
            tvsg_pkg::CMD_ADDR: begin
              rd_r       <= 8'd0;
              selected_r <= in_data.data[7:4] == 4'd0;
              sel_r      <= in_data.data[4:0];
            end
            tvsg_pkg::CMD_WRITE: begin
              rd_r <= 8'd0;
              if (selected_r) begin
                reg_file_r[sel_r[3:0]] <= in_data.data;
                if (sel_r[3:0] == 4'd13) begin
                  env_attack_r <= in_data.data[2] ? 4'hf : 4'h0;
                  env_hold_r   <= in_data.data[3] ? in_data.data[0] : 1'b1;
                  env_alt_r    <= in_data.data[3] ? in_data.data[1] : in_data.data[2];
                  env_step_r   <= 4'hf;
                  env_holding_r <= 1'b0;
                end
              end
            end
            tvsg_pkg::CMD_READ: rd_r <= selected_r ?
                (reg_file_r[sel_r[3:0]] & tvsg_pkg::read_mask(sel_r[3:0])) : 8'hff;
            default: rd_r <= 8'd0;
          endcase
        end
        tvsg_pkg::ST_TONE: begin
          if (div_start) div_busy_r <= 1'b1;
          if (div_done) begin
            div_busy_r <= 1'b0;
            if (quot != 12'd0) begin
              duty_r[ch_r]     <= duty_r[ch_r] - quot[4:0];
              tone_out_r[ch_r] <= duty_r[ch_r][0] ^ quot[0];
              tone_cnt_r[ch_r] <= rem;
            end else begin
              tone_cnt_r[ch_r] <= cnt_inc;
            end
            if (32'(ch_r) != NCH - 1) ch_r <= ch_r + CW'(1);
          end
        end
        tvsg_pkg::ST_NOISE: begin
          if (nz_fire) begin
            noise_cnt_r <= 5'd0;
            prescale_r  <= ~prescale_r;
            if (prescale_r) lfsr_r <= {lfsr_r[0] ^ lfsr_r[3], lfsr_r[16:1]};
          end else begin
            noise_cnt_r <= nz_inc;
          end
        end
        tvsg_pkg::ST_GATE: begin
          for (int c = 0; c < NCH; c++)
            gate_r[c] <= (tone_out_r[c] | en_bit(reg_file_r[7], c)) &
                         (lfsr_r[0] | en_bit(reg_file_r[7], c + 3));
        end
        tvsg_pkg::ST_ENV: if (!env_holding_r) begin
          if (env_fire) begin
            env_cnt_r <= 17'd0;
            if (env_step_r == 4'd0) begin
              if (env_alt_r) env_attack_r <= env_attack_r ^ 4'hf;
              if (env_hold_r) env_holding_r <= 1'b1;
              else env_step_r <= 4'hf;
            end else begin
              env_step_r <= env_step_r - 4'd1;
            end
          end else begin
            env_cnt_r <= env_inc;
          end
        end
        tvsg_pkg::ST_OUT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == tvsg_pkg::ST_OUT) begin
      out_r.read_data <= rd_r;
      out_r.level_a   <= lvl[0];
      out_r.env_a     <= env[0];
      out_r.level_b   <= lvl[1];
      out_r.env_b     <= env[1];
      out_r.level_c   <= lvl[2];
      out_r.env_c     <= env[2];
      out_r.sum_level <= sum;
    end
  end
  assign out_data = out_r;

  `TVSG_ASSERT_IMP(a_no_accept_busy, state_r != tvsg_pkg::ST_IDLE, !in_ready)
  `TVSG_ASSERT_NXT(a_out_follows, state_r == tvsg_pkg::ST_OUT, out_valid)
  `TVSG_ASSERT_IMP(a_lfsr_nonzero, 1'b1, lfsr_r != 17'd0)
  `TVSG_ASSERT_IMP(a_holding_step, env_holding_r, env_step_r == 4'd0)

endmodule
